// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the key/value table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define KVT_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Checks that a trigger implies a condition at the same clock edge.
`define KVT_ASSERT_IMPL(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Checks that a trigger implies a condition at the next clock edge.
`define KVT_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- design/kvt_pkg.sv -----
// Package with the sizes, request codes and payload types of the key/value table.
package kvt_pkg;

    localparam int ENTRIES    = 64;
    localparam int KEY_BITS   = 20;
    localparam int VALUE_BITS = 20;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] REQ_PUT    = 2'd0;
    localparam logic [1:0] REQ_GET    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_req;

    typedef struct packed {
        logic                  found;
        logic [VALUE_BITS-1:0] read_value;
        logic                  table_full;
    } t_rsp;

    // A request as it walks down the row of cells, with what it has gathered so far.
    typedef struct packed {
        logic                  v;
        t_req                  req;
        logic                  found;
        logic [VALUE_BITS-1:0] rd;
        logic                  free_seen;
        logic [IDX_W-1:0]      free_idx;
    } t_probe;

    // Write of a new pair into the slot chosen after the walk.
    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      idx;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_alloc;

endpackage

// ----- design/key_value_table_top.sv -----
// Top level of the key/value table: request intake, the row of slot cells and the result register.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         i_in_valid / o_in_stall   i_in_data  (t_req)
//   result    out        o_out_valid / i_out_stall o_out_data (t_rsp)
//
// A request is taken only while no other is in flight; the request walks the row of
// cells one slot per cycle, from the intake register through every cell, until it
// reaches the end of the row, and its result is then loaded into the output register.
// Reset (i_rst_n low at a clock edge) empties every slot and drops any request in flight.
// A stalled result holds the request at the end of the row; a new request is accepted
// as soon as the result of the previous one has moved into the output register.
module key_value_table_top import kvt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data
);

    // The probe chain: entry 0 is the intake register, entry ENTRIES is the last cell's output.
    t_probe w_chain [ENTRIES+1];

    t_probe r_head;
    t_probe n_head;
    logic   r_busy;
    logic   r_out_valid;
    t_rsp   r_out_data;
    t_rsp   n_out_data;
    t_alloc w_alloc;
    t_probe w_tail;
    logic   w_accept;
    logic   w_out_ready;
    logic   w_commit;
    logic   w_hold;
    logic   w_new_key;

    // Only one request is in flight at a time, so the intake stalls while one is under way.
    assign w_accept    = i_in_valid && !r_busy;
    assign w_tail      = w_chain[ENTRIES];
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_commit    = w_tail.v && w_out_ready;
    assign w_hold      = w_tail.v && !w_out_ready;

    always_comb begin
        n_head           = '0;
        n_head.v         = w_accept;
        n_head.req       = i_in_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.v <= 1'b0;
        end else begin
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_commit) begin
            r_busy <= 1'b0;
        end
    end

    assign w_chain[0] = r_head;

    // A put of a key that no slot held is stored in the first empty slot the walk met.
    assign w_new_key   = (w_tail.req.req_type == REQ_PUT) && !w_tail.found;
    assign w_alloc.en    = w_commit && w_new_key && w_tail.free_seen;
    assign w_alloc.idx   = w_tail.free_idx;
    assign w_alloc.key   = w_tail.req.key;
    assign w_alloc.value = w_tail.req.value;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        kvt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_probe (w_chain[g]),
            .i_hold  (w_hold),
            .i_alloc (w_alloc),
            .o_probe (w_chain[g+1])
        );
    end

    always_comb begin
        n_out_data.found      = w_tail.found;
        n_out_data.read_value = w_tail.rd;
        n_out_data.table_full = w_new_key && !w_tail.free_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- design/kvt_cell.sv -----
// One slot of the key/value table, with the probe stage that passes requests on.
module kvt_cell import kvt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_probe           i_probe,
    input  logic             i_hold,
    input  t_alloc           i_alloc,
    output t_probe           o_probe
);

    logic                  r_valid;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    t_probe                r_probe;
    t_probe                n_probe;
    logic                  w_op_ok;
    logic                  w_hit;
    logic                  w_alloc_me;

    assign w_op_ok = (i_probe.req.req_type == REQ_PUT) ||
                     (i_probe.req.req_type == REQ_GET) ||
                     (i_probe.req.req_type == REQ_REMOVE);
    assign w_hit = i_probe.v && w_op_ok && r_valid && (r_key == i_probe.req.key);
    assign w_alloc_me = i_alloc.en && (i_alloc.idx == i_index);

    always_comb begin
        n_probe = i_probe;
        if (w_hit) begin
            n_probe.found = 1'b1;
            if (i_probe.req.req_type == REQ_GET) begin
                n_probe.rd = r_value;
            end
        end
        // The first empty slot on the way is remembered for a put of a new key.
        if (i_probe.v && !r_valid && !i_probe.free_seen) begin
            n_probe.free_seen = 1'b1;
            n_probe.free_idx  = i_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.v <= 1'b0;
        end else if (!i_hold) begin
            r_probe <= n_probe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_hit && (i_probe.req.req_type == REQ_REMOVE)) begin
            r_valid <= 1'b0;
        end else if (w_alloc_me) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit && (i_probe.req.req_type == REQ_PUT)) begin
            r_value <= i_probe.req.value;
        end else if (w_alloc_me) begin
            r_key   <= i_alloc.key;
            r_value <= i_alloc.value;
        end
    end

    assign o_probe = r_probe;

endmodule

// ----- design/kvt_checker.sv -----
// Port-level checker for the key/value table and its bind to the top level.
`include "assert_macros.svh"

module kvt_checker import kvt_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_stall,
    input logic i_out_valid,
    input logic i_out_stall,
    input t_rsp i_out_data
);

    logic w_in_accept;
    logic w_held;
    logic w_full;
    logic w_rd_ok;

    assign w_in_accept = i_in_valid && !i_in_stall;
    assign w_held      = i_out_valid && i_out_stall;
    assign w_full      = i_out_valid && i_out_data.table_full;
    assign w_rd_ok     = !i_out_valid || (i_out_data.read_value == '0) || i_out_data.found;

    // A result that is held back stays offered and unchanged.
    `KVT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_held, i_out_valid, "result dropped")
    `KVT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_held, $stable(i_out_data), "result changed")
    // Once a request is taken, the table is busy with it in the next cycle.
    `KVT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_in_accept, i_in_stall, "two in flight")
    // A rejected put can only be for a key that was absent.
    `KVT_ASSERT_IMPL(a_full_absent, i_clk, i_rst_n, w_full, !i_out_data.found, "full with a hit")
    // A returned value implies the key was present.
    `KVT_ASSERT(a_value_found, i_clk, i_rst_n, w_rd_ok, "value without a hit")

endmodule

bind key_value_table_top kvt_checker u_kvt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

// ----- verif/testbench.sv -----
// Self-checking testbench for the key/value table: directed requests, random traffic, checks.
`timescale 1ns / 100ps

module testbench;
    import kvt_pkg::*;

    // The request code that the package leaves unnamed; the block must ignore it.
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    // A request occupies the row of cells from acceptance until its result moves into the output register.
    localparam int ITEM_CYCLES   = ENTRIES + 2;
    // The long hold-off of the result side, long enough to back the block up.
    localparam int HOLD_CYCLES   = 8 * ITEM_CYCLES;
    // Cycles without a single transaction on either channel before the run is abandoned.
    // The worst correct stretch is the hold-off plus one request plus random stalls.
    localparam int IDLE_LIMIT    = 8 * (HOLD_CYCLES + ITEM_CYCLES);
    localparam int PHASE_ITEMS   = 250;
    localparam int FILL_ITEMS    = 110;
    localparam int CHURN_ITEMS   = 70;
    localparam int KEY_POOL_SIZE = 80;
    localparam int REPORT_MAX    = 10;

    typedef enum logic [1:0] {MIX_FILL, MIX_CHURN, MIX_DRAIN} t_mix;

    // One row of the directed part. Rows with has_rsp set carry their expected result;
    // the others take it from the table model.
    typedef struct {
        t_req req;
        bit   has_rsp;
        t_rsp rsp;
    } t_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_req i_in_data   = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_rsp o_out_data;

    key_value_table_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Our own copy of the table contents. Keys and values are only looked at where the
    // slot is marked valid, just as in the block.
    bit                    tbl_valid [ENTRIES];
    logic [KEY_BITS-1:0]   tbl_key   [ENTRIES];
    logic [VALUE_BITS-1:0] tbl_value [ENTRIES];

    t_rsp                  pending_rsp[$];
    logic [KEY_BITS-1:0]   key_pool [KEY_POOL_SIZE];
    t_row                  directed_rows[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_armed     = 1'b0;
    bit in_reset       = 1'b1;

    int mismatches     = 0;
    int results_seen   = 0;
    int n_put          = 0;
    int n_get          = 0;
    int n_remove       = 0;
    int n_unknown      = 0;
    int n_get_hits     = 0;
    int n_rejected     = 0;
    int quiet_cycles   = 0;

    // Applies one request to the table copy and returns the result that it must produce.
    // A put of a new key lands in the lowest free slot; a full table turns it away.
    function automatic t_rsp table_apply(input t_req r);
        t_rsp rsp;
        int   hit;
        int   free_idx;
        rsp      = '0;
        hit      = -1;
        free_idx = -1;
        if (r.req_type == REQ_UNKNOWN) begin
            return rsp;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i] && tbl_key[i] == r.key && hit < 0) begin
                hit = i;
            end
            if (!tbl_valid[i] && free_idx < 0) begin
                free_idx = i;
            end
        end
        rsp.found = (hit >= 0);
        case (r.req_type)
            REQ_PUT: begin
                if (hit >= 0) begin
                    tbl_value[hit] = r.value;
                end else if (free_idx >= 0) begin
                    tbl_valid[free_idx] = 1'b1;
                    tbl_key[free_idx]   = r.key;
                    tbl_value[free_idx] = r.value;
                end else begin
                    rsp.table_full = 1'b1;
                end
            end
            REQ_GET: begin
                if (hit >= 0) begin
                    rsp.read_value = tbl_value[hit];
                end
            end
            REQ_REMOVE: begin
                if (hit >= 0) begin
                    tbl_valid[hit] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
                           input logic [VALUE_BITS-1:0] value, input bit has_rsp,
                           input logic found, input logic [VALUE_BITS-1:0] rd,
                           input logic full);
        t_row row;
        row.req.req_type    = op;
        row.req.key         = key;
        row.req.value       = value;
        row.has_rsp         = has_rsp;
        row.rsp.found       = found;
        row.rsp.read_value  = rd;
        row.rsp.table_full  = full;
        directed_rows       = {directed_rows, row};
    endtask

    // Random request. Keys mostly come from a small pool so that lookups hit and the
    // table fills; the fill mix walks the pool so that it reaches capacity quickly.
    function automatic t_req make_request(input t_mix mix, input int seq);
        t_req r;
        int   roll;
        int   put_pct;
        int   get_pct;
        int   rem_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin put_pct = 80; get_pct = 10; rem_pct = 5;  end
            MIX_CHURN: begin put_pct = 35; get_pct = 35; rem_pct = 25; end
            default:   begin put_pct = 10; get_pct = 25; rem_pct = 60; end
        endcase
        if (roll < put_pct) begin
            r.req_type = REQ_PUT;
        end else if (roll < put_pct + get_pct) begin
            r.req_type = REQ_GET;
        end else if (roll < put_pct + get_pct + rem_pct) begin
            r.req_type = REQ_REMOVE;
        end else begin
            r.req_type = REQ_UNKNOWN;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            r.key = KEY_BITS'($urandom);
        end else if (mix == MIX_FILL && roll < 75) begin
            r.key = key_pool[seq % KEY_POOL_SIZE];
        end else begin
            r.key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            r.value = '0;
        end else if (roll < 10) begin
            r.value = '1;
        end else begin
            r.value = VALUE_BITS'($urandom);
        end
        return r;
    endfunction

    // Offers one request and returns at the falling edge after it has been accepted.
    // The expected result is recorded at the accepting edge.
    task automatic send_request(input t_req r, input bit has_rsp, input t_rsp fixed_rsp);
        t_rsp predicted;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predicted = table_apply(r);
        pending_rsp = {pending_rsp, (has_rsp ? fixed_rsp : predicted)};
        case (r.req_type)
            REQ_PUT:    n_put++;
            REQ_GET:    n_get++;
            REQ_REMOVE: n_remove++;
            default:    n_unknown++;
        endcase
        if (r.req_type == REQ_GET && predicted.found) begin
            n_get_hits++;
        end
        if (predicted.table_full) begin
            n_rejected++;
        end
        @(negedge i_clk);
    endtask

    // Result side: random stalls at the current rate, plus one long hold-off when armed.
    // The hold-off is counted here so that the sender keeps offering meanwhile.
    initial begin : result_sink
        forever begin
            @(negedge i_clk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_out_stall <= (recv_stall_pct > 0) &&
                               ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Every result transaction is compared with the oldest expectation, field by field.
    always @(posedge i_clk) begin
        t_rsp want;
        if (!in_reset && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("Unexpected result: found=%0b value=%05h full=%0b",
                             o_out_data.found, o_out_data.read_value,
                             o_out_data.table_full);
                end
            end else begin
                want = pending_rsp.pop_front();
                if (o_out_data.found !== want.found ||
                    o_out_data.read_value !== want.read_value ||
                    o_out_data.table_full !== want.table_full) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("Result %0d differs: expected found=%0b value=%05h full=%0b,",
                                 results_seen, want.found, want.read_value, want.table_full);
                        $display("    got found=%0b value=%05h full=%0b",
                                 o_out_data.found, o_out_data.read_value,
                                 o_out_data.table_full);
                    end
                end
            end
        end
    end

    // Watchdog: any accepted transaction on either channel resets the count.
    always @(posedge i_clk) begin
        if (in_reset || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending_rsp.size());
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_rsp none;
        t_mix mix;
        none = '0;
        for (int i = 0; i < KEY_POOL_SIZE; i++) begin
            key_pool[i] = KEY_BITS'($urandom);
        end
        key_pool[0] = '0;
        key_pool[1] = '1;

        // Directed rows: extreme keys and values, every request code, and the corner
        // cases of lookup, update in place, removal of absent keys and unknown codes.
        add_row(REQ_GET,     20'h00000, 20'h00000, 1'b1, 1'b0, 20'h00000, 1'b0);
        add_row(REQ_REMOVE,  20'hFFFFF, 20'hFFFFF, 1'b1, 1'b0, 20'h00000, 1'b0);
        add_row(REQ_PUT,     20'h00000, 20'hFFFFF, 1'b1, 1'b0, 20'h00000, 1'b0);
        add_row(REQ_PUT,     20'hFFFFF, 20'h00000, 1'b1, 1'b0, 20'h00000, 1'b0);
        add_row(REQ_GET,     20'h00000, 20'h00000, 1'b1, 1'b1, 20'hFFFFF, 1'b0);
        add_row(REQ_GET,     20'hFFFFF, 20'hFFFFF, 1'b1, 1'b1, 20'h00000, 1'b0);
        add_row(REQ_PUT,     20'h00000, 20'h5A5A5, 1'b1, 1'b1, 20'h00000, 1'b0);
        add_row(REQ_GET,     20'h00000, 20'h00000, 1'b0, 1'b0, 20'h00000, 1'b0);
        add_row(REQ_UNKNOWN, 20'h00000, 20'hFFFFF, 1'b1, 1'b0, 20'h00000, 1'b0);
        add_row(REQ_GET,     20'h00000, 20'h12345, 1'b0, 1'b0, 20'h00000, 1'b0);
        add_row(REQ_REMOVE,  20'h00000, 20'h00000, 1'b1, 1'b1, 20'h00000, 1'b0);
        add_row(REQ_GET,     20'h00000, 20'h00000, 1'b1, 1'b0, 20'h00000, 1'b0);
        add_row(REQ_REMOVE,  20'h00000, 20'h00000, 1'b1, 1'b0, 20'h00000, 1'b0);
        add_row(REQ_PUT,     20'hAAAAA, 20'h55555, 1'b0, 1'b0, 20'h00000, 1'b0);
        add_row(REQ_PUT,     20'h55555, 20'hAAAAA, 1'b0, 1'b0, 20'h00000, 1'b0);
        add_row(REQ_GET,     20'h55555, 20'hFFFFF, 1'b0, 1'b0, 20'h00000, 1'b0);
        add_row(REQ_GET,     20'hAAAAA, 20'h00000, 1'b0, 1'b0, 20'h00000, 1'b0);
        add_row(REQ_REMOVE,  20'hFFFFF, 20'h00000, 1'b1, 1'b1, 20'h00000, 1'b0);
        add_row(REQ_UNKNOWN, 20'h12345, 20'h54321, 1'b1, 1'b0, 20'h00000, 1'b0);
        add_row(REQ_GET,     20'h00001, 20'hFFFFF, 1'b1, 1'b0, 20'h00000, 1'b0);
        add_row(REQ_PUT,     20'hFFFFF, 20'h00001, 1'b0, 1'b0, 20'h00000, 1'b0);

        // Synchronous reset, held for a number of clock cycles and never repeated.
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n  <= 1'b1;
        in_reset = 1'b0;
        @(negedge i_clk);

        // Three idling regimes: sender mostly busy with a stalling receiver, then the
        // reverse, then both at full rate with one long hold-off on the result side.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 12; recv_stall_pct = 67; end
                1:       begin send_idle_pct = 67; recv_stall_pct = 12; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            if (phase == 0) begin
                foreach (directed_rows[i]) begin
                    send_request(directed_rows[i].req, directed_rows[i].has_rsp,
                                 directed_rows[i].rsp);
                end
            end
            if (phase == 2) begin
                hold_armed = 1'b1;
            end
            // Each phase fills the table past capacity, churns it, then drains it.
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n < FILL_ITEMS) begin
                    mix = MIX_FILL;
                end else if (n < FILL_ITEMS + CHURN_ITEMS) begin
                    mix = MIX_CHURN;
                end else begin
                    mix = MIX_DRAIN;
                end
                send_request(make_request(mix, n), 1'b0, none);
            end
        end
        i_in_valid <= 1'b0;

        // Drain what is still in flight, then give a stray result time to show up.
        while (pending_rsp.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (ITEM_CYCLES + 4) @(posedge i_clk);

        $display("Covered %0d requests: %0d puts, %0d gets, %0d removes, %0d unknown codes.",
                 n_put + n_get + n_remove + n_unknown, n_put, n_get, n_remove, n_unknown);
        $display("Gets that hit: %0d; puts refused by a full table: %0d; results checked: %0d.",
                 n_get_hits, n_rejected, results_seen);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("Mismatching results: %0d", mismatches);
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/kvt_pkg.sv
design/kvt_cell.sv
design/key_value_table_top.sv
design/kvt_checker.sv
verif/testbench.sv
